// File: design/gelu_pkg.sv
// Package: default sizes and fixed-point constants for the GELU activation unit.
`default_nettype none

package gelu_pkg;

   localparam int SAMPLE_WIDTH_DEF     = 16;
   localparam int FRACTION_BITS_DEF    = 12;
   localparam int TANH_TABLE_STEPS_DEF = 256;

   // sqrt(2/pi) and 0.044715 as 0.32 fractions
   localparam logic [63:0] C1_Q32 = 64'd3426888095;
   localparam logic [63:0] C2_Q32 = 64'd192049463;

   // 1.0 in the 4.60 format used to build the tanh table
   localparam logic [63:0] Q60_ONE = 64'd1 << 60;

endpackage

`default_nettype wire

// File: design/gelu_tanh_activation_unit.sv
// GELU (tanh approximation) activation unit: nine-stage fixed-point pipeline.
//
// Usage:
//   A sample beat is taken at every rising clock edge with start high and busy low.
//   busy is high only while reset is asserted, so a new sample may be sent every
//   cycle. Each sample yields exactly one activation beat on rsp_activation,
//   marked by rsp_strobe for one cycle, in order of arrival.
//   The result of a sample taken at one edge is on the result ports, strobed,
//   once it has passed the register stages of all steps (clamp, square, cube,
//   inner sum, argument, table index, table read, interpolation, output
//   product). Throughput: one sample per cycle, set by the pipeline having one
//   register stage per step.
//   The receiver cannot stall; every result must be taken in its strobe cycle.
//   Reset (synchronous) clears all valid bits, so no result appears for a
//   sample that was in flight. The tanh table is a constant ROM built at
//   elaboration; it needs no fill after reset.
//   Formats: signed, FRACTION_BITS fraction bits. Inner argument saturates to
//   +-8; tanh is 1.0 for |argument| >= 4.
`default_nettype none

module gelu_tanh_activation_unit #(
   parameter int SAMPLE_WIDTH     = gelu_pkg::SAMPLE_WIDTH_DEF,
   parameter int FRACTION_BITS    = gelu_pkg::FRACTION_BITS_DEF,
   parameter int TANH_TABLE_STEPS = gelu_pkg::TANH_TABLE_STEPS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic signed [SAMPLE_WIDTH-1:0] req_sample,
   output logic                           rsp_strobe,
   output logic signed [SAMPLE_WIDTH-1:0] rsp_activation
);

   import gelu_pkg::*;

   localparam int SW  = SAMPLE_WIDTH;
   localparam int FB  = FRACTION_BITS;
   localparam int TS  = TANH_TABLE_STEPS;
   localparam int NST = 9;

   localparam int XCW = FB + 5;                   // clamped x, |xc| <= 8
   localparam int WW  = (SW > XCW) ? SW : XCW;
   localparam int X2W = FB + 8;
   localparam int X3W = FB + 11;
   localparam int C2W = FB - 2;
   localparam int C1W = FB + 1;
   localparam int TW  = FB + 7;
   localparam int P2W = 2 * XCW;
   localparam int P3W = X2W + XCW;
   localparam int P4W = C2W + X3W;
   localparam int P5W = C1W + TW;
   localparam int AMW = FB + 4;                   // |arg| <= 2^(FB+3)
   localparam int IW  = $clog2(TS + 1);
   localparam int SCW = AMW + IW;
   localparam int IXW = SCW - (FB + 2);
   localparam int FRW = FB + 2;
   localparam int TBW = FB + 1;
   localparam int GW  = FB + 2;
   localparam int IPW = TBW + FRW;
   localparam int POW = SW + GW + 1;

   localparam logic [63:0] C1_RND = (C1_Q32 + (64'd1 << (31 - FB))) >> (32 - FB);
   localparam logic [63:0] C2_RND = (C2_Q32 + (64'd1 << (31 - FB))) >> (32 - FB);
   localparam logic signed [C1W-1:0] C1 = $signed(C1_RND[C1W-1:0]);
   localparam logic signed [C2W-1:0] C2 = $signed(C2_RND[C2W-1:0]);

   localparam logic signed [WW-1:0] LIM_W = $signed(WW'(1) << (FB + 3));
   localparam logic signed [TW-1:0] LIM_T = $signed(TW'(1) << (FB + 3));
   localparam logic [TBW-1:0]       ONE_T = TBW'(1) << FB;
   localparam logic [GW-1:0]        ONE_G = GW'(1) << FB;

   // restoring division, elaboration only
   function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
      logic [64:0] rem;
      logic [63:0] q;
      rem = '0;
      q   = '0;
      for (int i = 63; i >= 0; i--) begin
         rem = {rem[63:0], num[i]};
         q   = q << 1;
         if (rem >= {1'b0, den}) begin
            rem  = rem - {1'b0, den};
            q[0] = 1'b1;
         end
      end
      return q;
   endfunction

   function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
      logic [127:0] p;
      p = {64'd0, a} * {64'd0, b};
      return p[123:60];
   endfunction

   // tanh(4k/TS) in FB fraction bits, via exp(-2t) series and a long division
   function automatic logic [TS:0][TBW-1:0] build_rom();
      logic [TS:0][TBW-1:0] rom;
      logic [63:0]          d;
      logic [63:0]          base;
      logic [63:0]          term;
      logic [63:0]          e;
      logic [63:0]          rem;
      logic [63:0]          den;
      logic [63:0]          q;
      logic [63:0]          rnd;
      d    = udiv64(64'd1 << 63, 64'(TS));
      base = Q60_ONE;
      term = Q60_ONE;
      e    = Q60_ONE;
      for (int n = 1; n <= 40; n++) begin
         term = udiv64(mul_q60(term, d), 64'(n));
         if (n[0]) begin
            base = base - term;
         end else begin
            base = base + term;
         end
      end
      for (int k = 0; k <= TS; k++) begin
         rem = Q60_ONE - e;
         den = Q60_ONE + e;
         q   = '0;
         for (int i = 0; i <= FB; i++) begin
            rem = rem << 1;
            q   = q << 1;
            if (rem >= den) begin
               rem  = rem - den;
               q[0] = 1'b1;
            end
         end
         rnd    = (q + 64'd1) >> 1;
         rom[k] = rnd[TBW-1:0];
         e      = mul_q60(e, base);
      end
      return rom;
   endfunction

   localparam logic [TS:0][TBW-1:0] TANH_ROM = build_rom();

   // valid bits: [0] stage 1 ... [NST-1] output register
   logic [NST-1:0] vld_ff, vld_in;
   logic           accept;

   logic signed [SW-1:0]  x_ff [1:NST-1];
   logic signed [XCW-1:0] xc_s1_ff, xc_s2_ff, xc_s3_ff, xc_in;
   logic signed [X2W-1:0] x2_s2_ff, x2_in;
   logic signed [X3W-1:0] x3_s3_ff, x3_in;
   logic signed [TW-1:0]  t_s4_ff, t_in;
   logic signed [XCW-1:0] arg_s5_ff, arg_in;
   logic [IXW-1:0]        idx_s6_ff, idx_in;
   logic [FRW-1:0]        frac_s6_ff, frac_s7_ff, frac_in;
   logic                  neg_s6_ff, neg_s7_ff, neg_in;
   logic [TBW-1:0]        lo_s7_ff, lo_in, diff_s7_ff, diff_in;
   logic                  sat_s7_ff, sat_in;
   logic [GW-1:0]         g_s8_ff, g_in;
   logic signed [SW-1:0]  act_ff, act_in;

   assign busy   = reset;
   assign accept = start & ~busy;
   assign vld_in = {vld_ff[NST-2:0], accept};

   // stage 1: clamp x to +-8 for the argument path
   logic signed [WW-1:0] x_w, xc_w;
   assign x_w  = WW'(req_sample);
   assign xc_w = (x_w > LIM_W) ? LIM_W : ((x_w < -LIM_W) ? -LIM_W : x_w);
   assign xc_in = XCW'(xc_w);

   // stage 2: x^2
   logic signed [P2W-1:0] p2, s2;
   assign p2    = xc_s1_ff * xc_s1_ff;
   assign s2    = p2 + $signed(P2W'(1) << (FB - 1));
   assign x2_in = X2W'(s2 >>> FB);

   // stage 3: x^3
   logic signed [P3W-1:0] p3, s3;
   assign p3    = x2_s2_ff * xc_s2_ff;
   assign s3    = p3 + $signed(P3W'(1) << (FB - 1));
   assign x3_in = X3W'(s3 >>> FB);

   // stage 4: x + c2*x^3
   logic signed [P4W-1:0] p4, s4;
   assign p4   = C2 * x3_s3_ff;
   assign s4   = p4 + $signed(P4W'(1) << (FB - 1));
   assign t_in = TW'(xc_s3_ff) + TW'(s4 >>> FB);

   // stage 5: c1*t, saturated to +-8
   logic signed [P5W-1:0] p5, s5;
   logic signed [TW-1:0]  a5;
   assign p5     = C1 * t_s4_ff;
   assign s5     = p5 + $signed(P5W'(1) << (FB - 1));
   assign a5     = TW'(s5 >>> FB);
   assign arg_in = XCW'((a5 > LIM_T) ? LIM_T : ((a5 < -LIM_T) ? -LIM_T : a5));

   // stage 6: |arg| in table steps, split into index and fraction
   logic signed [XCW-1:0] mag6;
   logic [SCW-1:0]        scaled;
   assign neg_in  = arg_s5_ff[XCW-1];
   assign mag6    = neg_in ? -arg_s5_ff : arg_s5_ff;
   assign scaled  = SCW'(mag6[AMW-1:0]) * SCW'(TS);
   assign idx_in  = scaled[SCW-1:FB+2];
   assign frac_in = scaled[FRW-1:0];

   // stage 7: table read of both neighbors
   logic [IW-1:0]  rd_lo, rd_hi;
   logic [TBW-1:0] hi7;
   assign sat_in  = idx_s6_ff >= IXW'(TS);
   assign rd_lo   = sat_in ? '0 : idx_s6_ff[IW-1:0];
   assign rd_hi   = rd_lo + IW'(1);
   assign lo_in   = TANH_ROM[rd_lo];
   assign hi7     = TANH_ROM[rd_hi];
   assign diff_in = hi7 - lo_in;

   // stage 8: interpolate, apply sign, form 1 + tanh
   logic [IPW-1:0] ip;
   logic [IPW-1:0] ipr;
   logic [TBW-1:0] y8, th8;
   assign ip   = diff_s7_ff * frac_s7_ff;
   assign ipr  = (ip + (IPW'(1) << (FB + 1))) >> (FB + 2);
   assign y8   = lo_s7_ff + ipr[TBW-1:0];
   assign th8  = sat_s7_ff ? ONE_T : y8;
   assign g_in = neg_s7_ff ? (ONE_G - GW'(th8)) : (ONE_G + GW'(th8));

   // stage 9: x * (1 + tanh) / 2, rounded
   logic signed [POW-1:0] po, s9;
   assign po     = x_ff[NST-1] * $signed({1'b0, g_s8_ff});
   assign s9     = po + $signed(POW'(1) << FB);
   assign act_in = SW'(s9 >>> (FB + 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff[1]    <= req_sample;
      for (int s = 2; s <= NST - 1; s++) begin
         x_ff[s] <= x_ff[s-1];
      end
      xc_s1_ff   <= xc_in;
      xc_s2_ff   <= xc_s1_ff;
      xc_s3_ff   <= xc_s2_ff;
      x2_s2_ff   <= x2_in;
      x3_s3_ff   <= x3_in;
      t_s4_ff    <= t_in;
      arg_s5_ff  <= arg_in;
      idx_s6_ff  <= idx_in;
      frac_s6_ff <= frac_in;
      neg_s6_ff  <= neg_in;
      frac_s7_ff <= frac_s6_ff;
      neg_s7_ff  <= neg_s6_ff;
      lo_s7_ff   <= lo_in;
      diff_s7_ff <= diff_in;
      sat_s7_ff  <= sat_in;
      g_s8_ff    <= g_in;
      act_ff     <= act_in;
   end

   assign rsp_strobe     = vld_ff[NST-1];
   assign rsp_activation = act_ff;

`ifndef ASSERT_OFF
   // every beat taken comes out after the full pipeline depth
   a_latency_fwd: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##NST rsp_strobe)
      else $error("result beat missing at pipeline exit");

   // no result without a beat taken the pipeline depth earlier
   a_latency_rev: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(accept, NST))
      else $error("result beat without matching sample");

   // GELU lies between 0 and x
   a_out_bounds: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |->
         (($past(req_sample, NST) >= 0) && (rsp_activation >= 0) &&
          (rsp_activation <= $past(req_sample, NST))) ||
         (($past(req_sample, NST) < 0) && (rsp_activation <= 0) &&
          (rsp_activation >= $past(req_sample, NST))))
      else $error("activation outside [0, x]");

   // 1 + tanh stays within [0, 2]
   a_gain_range: assert property (@(posedge clock) disable iff (reset)
      vld_ff[NST-2] |-> (g_s8_ff <= (ONE_G << 1)))
      else $error("1 + tanh out of range");
`endif

endmodule

`default_nettype wire

// File: tb/tb.sv
`timescale 1ns / 1ps
// Testbench for the GELU tanh activation unit: directed and random samples checked bit-exact.
module tb;
   import gelu_pkg::*;

   localparam int SW    = SAMPLE_WIDTH_DEF;
   localparam int FB    = FRACTION_BITS_DEF;
   localparam int STEPS = TANH_TABLE_STEPS_DEF;
   localparam longint LIM = longint'(8) << FB;

   typedef logic signed [SW-1:0] sample_type;
   typedef struct {
      sample_type sample;
      sample_type activation;
   } gelu_beat_type;

   logic       clock = 1'b0;
   logic       reset;
   logic       start;
   logic       busy;
   sample_type req_sample;
   logic       rsp_strobe;
   sample_type rsp_activation;

   gelu_tanh_activation_unit dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_sample     (req_sample),
      .rsp_strobe     (rsp_strobe),
      .rsp_activation (rsp_activation)
   );

   always #10 clock = ~clock;

   logic [63:0]   tanh_tab [0:STEPS];
   gelu_beat_type pending_q[$];
   int            errors = 0;
   int            samples_sent = 0;
   int            results_seen = 0;
   bit            no_idle = 1'b0;

   // (a*b) >> 60 in the 4.60 format
   function automatic logic [63:0] q60_mul(logic [63:0] a, logic [63:0] b);
      logic [127:0] p;
      p = {64'd0, a} * {64'd0, b};
      return p[123:60];
   endfunction

   // tanh(4k/STEPS) from exp(-2t), rounded to FB fraction bits
   function automatic void build_tanh_tab();
      logic [63:0] d, base, term, e, rem, den, q;
      d    = (64'd8 << 60) / STEPS;
      base = Q60_ONE;
      term = Q60_ONE;
      e    = Q60_ONE;
      for (int n = 1; n <= 40; n++) begin
         term = q60_mul(term, d) / 64'(n);
         if (n % 2) base = base - term;
         else base = base + term;
      end
      for (int k = 0; k <= STEPS; k++) begin
         rem = Q60_ONE - e;
         den = Q60_ONE + e;
         q   = 64'd0;
         for (int i = 0; i <= FB; i++) begin
            rem = rem << 1;
            q   = q << 1;
            if (rem >= den) begin
               rem  = rem - den;
               q[0] = 1'b1;
            end
         end
         tanh_tab[k] = (q + 64'd1) >> 1;
         e = q60_mul(e, base);
      end
   endfunction

   // floor(v / 2^s + 1/2)
   function automatic longint round_half_up(longint v, int s);
      return (v + (longint'(1) << (s - 1))) >>> s;
   endfunction

   function automatic longint tanh_interp(longint arg);
      longint mag, scaled, idx, frac, lo, hi, y;
      mag    = (arg < 0) ? -arg : arg;
      scaled = mag * STEPS;
      idx    = scaled >>> (FB + 2);
      frac   = scaled & ((longint'(1) << (FB + 2)) - 1);
      if (idx >= STEPS) begin
         y = longint'(1) << FB;
      end else begin
         lo = longint'(tanh_tab[idx]);
         hi = longint'(tanh_tab[idx + 1]);
         y  = lo + (((hi - lo) * frac + (longint'(1) << (FB + 1))) >>> (FB + 2));
      end
      return (arg < 0) ? -y : y;
   endfunction

   function automatic sample_type gelu_expected(sample_type s);
      longint c1, c2, x, xc, x2, x3, t, arg, y;
      c1  = longint'((C1_Q32 + (64'd1 << (31 - FB))) >> (32 - FB));
      c2  = longint'((C2_Q32 + (64'd1 << (31 - FB))) >> (32 - FB));
      x   = longint'(s);
      xc  = (x > LIM) ? LIM : ((x < -LIM) ? -LIM : x);
      x2  = round_half_up(xc * xc, FB);
      x3  = round_half_up(x2 * xc, FB);
      t   = xc + round_half_up(c2 * x3, FB);
      arg = round_half_up(c1 * t, FB);
      if (arg > LIM) arg = LIM;
      if (arg < -LIM) arg = -LIM;
      y   = round_half_up(x * ((longint'(1) << FB) + tanh_interp(arg)), FB + 1);
      return sample_type'(y);
   endfunction

   // outputs settle at the rising edge, so the falling edge sees the accepted beat
   always @(negedge clock) begin
      gelu_beat_type want;
      if (reset === 1'b0 && rsp_strobe === 1'b1) begin
         results_seen++;
         if (pending_q.size() == 0) begin
            errors++;
            $display("%0t: unexpected activation beat: expected none, actual %0d",
                     $time, rsp_activation);
         end else begin
            want = pending_q.pop_front();
            if (rsp_activation !== want.activation) begin
               errors++;
               $display("%0t: sample %0d: expected activation %0d, actual %0d",
                        $time, want.sample, want.activation, rsp_activation);
            end
         end
      end
   end

   task automatic send_sample(sample_type v);
      bit held;
      req_sample <= v;
      start      <= 1'b1;
      do begin
         @(negedge clock);
         held = (busy !== 1'b0);
         @(posedge clock);
      end while (held);
      pending_q.push_back('{sample: v, activation: gelu_expected(v)});
      samples_sent++;
   endtask

   task automatic idle_gap();
      int n;
      n = no_idle ? 0 : $urandom_range(0, 4);
      if (n > 0) begin
         start      <= 1'b0;
         req_sample <= sample_type'($urandom);
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic send_and_idle(sample_type v);
      send_sample(v);
      idle_gap();
   endtask

   task automatic drain();
      start <= 1'b0;
      while (pending_q.size() != 0) @(posedge clock);
   endtask

   // zero, one lsb, range ends, tanh table end, argument saturation, bit patterns
   task automatic test_directed();
      sample_type pts[] = '{16'sd0, 16'sd1, -16'sd1, 16'sd2, -16'sd3, 16'sh7fff, 16'sh8000,
                            16'sd4096, -16'sd4096, 16'sd2048, -16'sd2048, 16'sd8192,
                            -16'sd8192, 16'sd10240, -16'sd10240, 16'sd13660, 16'sd13700,
                            -16'sd13680, 16'sd20000, -16'sd20000, 16'sh5555, 16'shaaaa,
                            16'sd12288, -16'sd12288};
      no_idle = 1'b0;
      foreach (pts[i]) send_and_idle(pts[i]);
      drain();
   endtask

   task automatic test_random_full(int n);
      for (int i = 0; i < n; i++) begin
         if (i % 64 == 0) no_idle = ($urandom_range(0, 3) == 0);
         send_and_idle(sample_type'($urandom));
      end
      drain();
   endtask

   // |x| up to 5: the interpolated part of the tanh curve
   task automatic test_random_knee(int n);
      for (int i = 0; i < n; i++) begin
         if (i % 64 == 0) no_idle = ($urandom_range(0, 3) == 0);
         send_and_idle(sample_type'(int'($urandom_range(0, 40960)) - 20480));
      end
      drain();
   endtask

   // near zero, where rounding decides most bits
   task automatic test_random_near_zero(int n);
      for (int i = 0; i < n; i++) begin
         if (i % 64 == 0) no_idle = ($urandom_range(0, 2) == 0);
         send_and_idle(sample_type'(int'($urandom_range(0, 1024)) - 512));
      end
      drain();
   endtask

   initial begin
      build_tanh_tab();
      reset      = 1'b1;
      start      = 1'b0;
      req_sample = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_random_full(700);
      test_random_knee(700);
      test_random_near_zero(450);
      repeat (12) @(posedge clock);
      $display("Sent %0d samples (range ends, tanh knee, near-zero sweeps, back-to-back bursts);",
               samples_sent);
      $display("checked %0d activation beats, %0d mismatches", results_seen, errors);
      if (errors == 0 && pending_q.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   initial begin
      #5000000;
      $display("Timeout with %0d activations outstanding", pending_q.size());
      $display("FAILED: results differ");
      $finish;
   end

endmodule

// File: files.f
design/gelu_pkg.sv
design/gelu_tanh_activation_unit.sv
tb/tb.sv
